// File: hw/rtl/macd_pkg.sv
// Shared widths, register codes and types for the multi-channel debouncer.
package macd_pkg;

    localparam int RAW_W      = 7;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 8;
    localparam int CLR_MS_W   = 13;
    localparam int LIMIT_W    = 23;   // 8191 ms * 1000 fits in 23 bits
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CHANNELS_DEF = 7;

    localparam logic [9:0] US_PER_MS = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_MS    = 2'd2;

    localparam logic [RAW_W-1:0]    ACTIVE_LOW_RST = '0;
    localparam logic [CNT_W-1:0]    SET_SAMPLES_RST = 8'd3;
    localparam logic [LIMIT_W-1:0]  CLEAR_LIMIT_RST = 23'd100000;

    typedef struct packed {
        logic [CNT_W-1:0]   set_samples;
        logic [LIMIT_W-1:0] clear_limit;
    } t_chan_cfg;

    typedef struct packed {
        logic              advance;
        logic              detected;
        logic [TIME_W-1:0] now;
    } t_chan_ctl;

endpackage

// File: hw/rtl/macd_chan.sv
// One debounce channel: detect counter, clear timer and confirmed flag.
module macd_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  macd_pkg::t_chan_cfg i_cfg,
    input  macd_pkg::t_chan_ctl i_ctl,
    output logic                o_confirmed_next
);
    import macd_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0] r_start, n_start;
    logic              r_clearing, n_clearing;
    logic              r_confirmed, n_confirmed;
    logic [TIME_W-1:0] elapsed;

    always_comb begin
        n_count     = r_count;
        n_start     = r_start;
        n_clearing  = r_clearing;
        n_confirmed = r_confirmed;
        elapsed     = '0;
        if (i_ctl.detected) begin
            if (r_count < i_cfg.set_samples) begin
                n_count = r_count + 1'b1;
            end
            if (n_count >= i_cfg.set_samples) begin
                n_confirmed = 1'b1;
            end
            n_clearing = 1'b0;
        end else begin
            n_count = '0;
            if (!r_clearing) begin
                n_start = i_ctl.now;
            end
            n_clearing = 1'b1;
            elapsed = i_ctl.now - n_start;
            if (elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.clear_limit}) begin
                n_confirmed = 1'b0;
            end
        end
    end

    assign o_confirmed_next = n_confirmed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clearing  <= 1'b0;
            r_confirmed <= 1'b0;
        end else if (i_ctl.advance) begin
            r_count     <= n_count;
            r_clearing  <= n_clearing;
            r_confirmed <= n_confirmed;
        end
    end

    // start time is only read while clearing is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_start <= n_start;
        end
    end

endmodule

// File: hw/rtl/multi_channel_asymmetric_debouncer.sv
// Top level of the multi-channel asymmetric debouncer.
//
// Input channel: one beat per sample, i_time_us (microsecond timestamp that
// wraps) and i_raw_bits (one raw level per channel). A beat is taken when
// i_valid is high and o_stall is low. Output channel: one beat per sample,
// o_confirmed_bits, taken when o_valid is high and i_stall is low.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 polarity mask, 1 set sample count, 2 clear time in ms). Write only
// while the block is idle. Other indexes are ignored.
// An accepted sample goes to the input register, then the result register.
// Throughput: one sample per cycle unless i_stall holds a result; the input
// register, per-channel update logic and result register: a two-deep pipe.
// Channel state changes when a sample moves from the input register to the
// result register, which needs the result register empty or being taken.
// Stall: with i_stall high and a result waiting, one more sample is held in
// the input register, then o_stall rises. Nothing is dropped.
// Reset (synchronous, i_rst_n low): all channels unconfirmed, counters and
// clear timers idle, both pipe stages empty, registers to defaults
// (mask 0, 3 samples, 100 ms).
module multi_channel_asymmetric_debouncer #(
    parameter int CHANNELS = macd_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [macd_pkg::TIME_W-1:0]     i_time_us,
    input  logic [macd_pkg::RAW_W-1:0]      i_raw_bits,
    // result output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [macd_pkg::RAW_W-1:0]      o_confirmed_bits,
    // config
    input  logic                            i_cfg_we,
    input  logic [macd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [macd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import macd_pkg::*;

    // config registers; clear time kept as microseconds
    logic [RAW_W-1:0]   r_active_low;
    logic [CNT_W-1:0]   r_set_samples;
    logic [LIMIT_W-1:0] r_clear_limit;
    logic [LIMIT_W-1:0] clear_limit_wr;

    // pipe stages
    logic               r_in_valid;
    logic [TIME_W-1:0]  r_in_time;
    logic [RAW_W-1:0]   r_in_raw;
    logic               r_out_valid;
    logic [RAW_W-1:0]   r_out_bits;
    logic [RAW_W-1:0]   n_out_bits;

    logic               out_free;
    logic               advance;
    logic               in_take;
    logic [CHANNELS-1:0] conf_next;
    t_chan_cfg          chan_cfg;

    assign clear_limit_wr = LIMIT_W'(i_cfg_data[CLR_MS_W-1:0]) * LIMIT_W'(US_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low  <= ACTIVE_LOW_RST;
            r_set_samples <= SET_SAMPLES_RST;
            r_clear_limit <= CLEAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACTIVE_LOW:  r_active_low  <= i_cfg_data[RAW_W-1:0];
                REG_SET_SAMPLES: r_set_samples <= i_cfg_data[CNT_W-1:0];
                REG_CLEAR_MS:    r_clear_limit <= clear_limit_wr;
                default: ;
            endcase
        end
    end

    // handshake: result slot frees when empty or being taken
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_time <= i_time_us;
            r_in_raw  <= i_raw_bits;
        end
        if (advance) begin
            r_out_bits <= n_out_bits;
        end
    end

    assign chan_cfg.set_samples = r_set_samples;
    assign chan_cfg.clear_limit = r_clear_limit;

    // one cell per channel; channels past the field width never detect
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        t_chan_ctl ctl;
        assign ctl.advance = advance;
        assign ctl.now     = r_in_time;
        if (g < RAW_W) begin : g_det
            assign ctl.detected = r_in_raw[g] ^ r_active_low[g];
        end else begin : g_nodet
            assign ctl.detected = 1'b0;
        end
        macd_chan u_chan (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_cfg            (chan_cfg),
            .i_ctl            (ctl),
            .o_confirmed_next (conf_next[g])
        );
    end

    // result field: bits for absent channels read zero
    for (genvar b = 0; b < RAW_W; b++) begin : g_out
        if (b < CHANNELS) begin : g_live
            assign n_out_bits[b] = conf_next[b];
        end else begin : g_dead
            assign n_out_bits[b] = 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_confirmed_bits = r_out_bits;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_in_valid)
        else $error("pipe not empty after reset");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted sample lost from input register");

    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("sample moved but no result shown");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_time) && $stable(r_in_raw))
        else $error("held sample changed while blocked");

    a_dead_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_confirmed_bits & ~n_out_mask()) == '0)
        else $error("result bit set for absent channel");
`endif

    function automatic logic [RAW_W-1:0] n_out_mask();
        logic [RAW_W-1:0] m;
        m = '0;
        for (int k = 0; k < RAW_W; k++) begin
            if (k < CHANNELS) begin
                m[k] = 1'b1;
            end
        end
        return m;
    endfunction

endmodule

// File: tb/sv/tb_multi_channel_asymmetric_debouncer.sv
// Testbench for the multi-channel asymmetric debouncer: random handshakes, self-checking.
`timescale 1ns / 100ps

module tb_multi_channel_asymmetric_debouncer;
    import macd_pkg::*;

    // Index 3 is not a register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic [TIME_W-1:0]     i_time_us    = '0;
    logic [RAW_W-1:0]      i_raw_bits   = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [RAW_W-1:0]      o_confirmed_bits;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    multi_channel_asymmetric_debouncer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_time_us        (i_time_us),
        .i_raw_bits       (i_raw_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_confirmed_bits (o_confirmed_bits),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Debounce state as the block should hold it, at reset values.
    logic [RAW_W-1:0]      pol_mask = '0;
    logic [CNT_W-1:0]      set_n    = 8'd3;
    logic [CLR_MS_W-1:0]   clr_ms   = 13'd100;
    logic [CNT_W-1:0]      det_cnt   [RAW_W];
    logic [TIME_W-1:0]     clr_start [RAW_W];
    logic [RAW_W-1:0]      clearing  = '0;
    logic [RAW_W-1:0]      confirmed = '0;

    logic [RAW_W-1:0]      confirm_q[$];   // confirmed masks still to come out
    logic [TIME_W-1:0]     now_us = '0;
    int                    errors = 0;
    int                    samples_sent = 0;
    int                    results_seen = 0;
    int                    reg_writes = 0;
    int                    burst_left = 0;

    initial begin
        for (int i = 0; i < RAW_W; i++) begin
            det_cnt[i]   = '0;
            clr_start[i] = '0;
        end
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ACTIVE_LOW:  pol_mask = data[RAW_W-1:0];
            REG_SET_SAMPLES: set_n    = data[CNT_W-1:0];
            REG_CLEAR_MS:    clr_ms   = data[CLR_MS_W-1:0];
            default: ;
        endcase
    endfunction

    // One sample through all channels; returns the new confirmed mask.
    function automatic logic [RAW_W-1:0] debounce_step(input logic [TIME_W-1:0] t,
                                                       input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0]  det;
        logic [TIME_W-1:0] clear_us;
        det      = raw ^ pol_mask;
        clear_us = 32'(clr_ms) * 32'(US_PER_MS);
        for (int i = 0; i < RAW_W; i++) begin
            if (det[i]) begin
                if (det_cnt[i] < set_n)
                    det_cnt[i] = det_cnt[i] + 8'd1;
                if (det_cnt[i] >= set_n)
                    confirmed[i] = 1'b1;
                clearing[i] = 1'b0;
            end else begin
                det_cnt[i] = '0;
                if (!clearing[i]) begin
                    clr_start[i] = t;
                    clearing[i]  = 1'b1;
                end
                if (TIME_W'(t - clr_start[i]) >= clear_us)
                    confirmed[i] = 1'b0;
            end
        end
        return confirmed;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(80, 30);
    endfunction

    // Next timestamp: small steps, steps near the clear time, exact hits on a
    // channel's clear deadline, and full-range jumps.
    function automatic logic [TIME_W-1:0] step_time();
        logic [TIME_W-1:0] lim;
        int unsigned       r;
        lim = 32'(clr_ms) * 32'(US_PER_MS);
        r   = $urandom_range(99);
        if (r < 40)
            now_us += $urandom_range(40);
        else if (r < 62)
            now_us += $urandom_range(lim / 4 + 1);
        else if (r < 80)
            now_us = clr_start[$urandom_range(RAW_W - 1)] + lim - 1 + $urandom_range(1);
        else if (r < 95)
            now_us += $urandom_range(2 * lim + 100);
        else
            now_us = $urandom;
        return now_us;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 30)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Sends one sample beat and holds it until taken.
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [RAW_W-1:0] raw);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(24) == 0) begin
            burst_left = $urandom_range(60, 20);
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_time_us  <= t;
        i_raw_bits <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        confirm_q.push_back(debounce_step(t, raw));
        samples_sent++;
    endtask

    // Drain the pipe so registers can be written safely.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (confirm_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    // Reset defaults: confirm on the third detection, clear after exactly 100 ms.
    task automatic test_reset_defaults();
        send_sample(32'd1000, 7'h00);
        send_sample(32'd1010, 7'h7F);
        send_sample(32'd1020, 7'h7F);
        send_sample(32'd1030, 7'h7F);
        send_sample(32'd2000, 7'h00);      // clear timers start
        send_sample(32'd101999, 7'h00);    // one microsecond short
        send_sample(32'd102000, 7'h0F);    // low half re-detected, high half clears
    endtask

    task automatic test_zero_thresholds();
        wait_idle();
        write_reg(REG_SET_SAMPLES, 13'd0);
        write_reg(REG_CLEAR_MS, 13'd0);
        send_sample(32'd0, 7'h2A);
        send_sample(32'hFFFF_FFFF, 7'h55);
    endtask

    // Upper data bits must be dropped; the unused index must change nothing.
    task automatic test_polarity_and_widths();
        wait_idle();
        write_reg(REG_ACTIVE_LOW, 13'h1FD5);
        write_reg(REG_UNUSED, 13'h1FFF);
        send_sample(32'h5555_5555, 7'h55);
        send_sample(32'hAAAA_AAAA, 7'h2A);
    endtask

    // A count above a newly lowered threshold still confirms.
    task automatic test_lowered_threshold();
        wait_idle();
        write_reg(REG_ACTIVE_LOW, 13'h0000);
        write_reg(REG_SET_SAMPLES, 13'h1F06);
        send_sample(32'd500, 7'h00);
        for (int k = 0; k < 5; k++)
            send_sample(32'd501 + k, 7'h7F);
        wait_idle();
        write_reg(REG_SET_SAMPLES, 13'd3);
        send_sample(32'd600, 7'h7F);
    endtask

    // Clear deadline that lies across the timestamp wrap.
    task automatic test_timestamp_wrap();
        wait_idle();
        write_reg(REG_SET_SAMPLES, 13'd1);
        write_reg(REG_CLEAR_MS, 13'd1);
        send_sample(32'hFFFF_FF00, 7'h7F);
        send_sample(32'hFFFF_FFF0, 7'h00);
        send_sample(32'h0000_03D7, 7'h00); // 999 us elapsed
        send_sample(32'h0000_03D8, 7'h00); // 1000 us elapsed
    endtask

    // Phases of random traffic, each under its own register setting. Most
    // traffic holds a level pattern for 1 to set_n + 4 samples, some bouncing.
    task automatic test_random_phases();
        int                    n;
        int                    sent;
        int                    run;
        logic [RAW_W-1:0]      level;
        logic [RAW_W-1:0]      raw;
        logic [CFG_DATA_W-1:0] d_mask;
        logic [CFG_DATA_W-1:0] d_set;
        logic [CFG_DATA_W-1:0] d_clr;
        bit                    bouncy;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    d_mask = '0;
                    d_set  = '0;
                    d_clr  = '0;
                end
                1: begin
                    d_mask = 13'h1FFF;
                    d_set  = 13'h00FF;
                    d_clr  = 13'h1FFF;
                end
                2: begin
                    d_mask = 13'h007F;
                    d_set  = 13'd1;
                    d_clr  = 13'd4294;
                end
                default: begin
                    d_mask = 13'($urandom_range(8191));
                    d_set  = 13'($urandom_range(8)) | (13'($urandom_range(31)) << 8);
                    d_clr  = 13'($urandom_range(40));
                end
            endcase
            wait_idle();
            write_reg(REG_ACTIVE_LOW, d_mask);
            write_reg(REG_SET_SAMPLES, d_set);
            write_reg(REG_CLEAR_MS, d_clr);
            if ($urandom_range(1))
                write_reg(REG_UNUSED, 13'($urandom_range(8191)));
            now_us = (ph == 4) ? 32'hFFFF_0000 : $urandom;
            n    = (ph == 1) ? 300 : 115;
            sent = 0;
            while (sent < n) begin
                if ($urandom_range(9) < 8) begin
                    level  = 7'($urandom_range(127));
                    run    = $urandom_range(int'(set_n) + 4, 1);
                    bouncy = ($urandom_range(3) == 0);
                    for (int k = 0; k < run && sent < n; k++) begin
                        raw = level;
                        if (bouncy && $urandom_range(7) == 0)
                            raw[$urandom_range(RAW_W - 1)] ^= 1'b1;
                        send_sample(step_time(), raw);
                        sent++;
                    end
                end else begin
                    run = $urandom_range(4, 1);
                    for (int k = 0; k < run && sent < n; k++) begin
                        now_us = $urandom;
                        send_sample(now_us, 7'($urandom_range(127)));
                        sent++;
                    end
                end
            end
        end
    endtask

    // Result side: random stalls, with occasional long open stretches.
    initial begin : stall_gen
        int hold;
        @(posedge i_clk);
        forever begin
            i_stall <= 1'b0;
            if ($urandom_range(9) == 0)
                repeat (200) @(posedge i_clk);
            else
                repeat ($urandom_range(12, 1)) @(posedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Every result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        logic [RAW_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (confirm_q.size() == 0) begin
                report_mismatch($sformatf("result %h with none expected", o_confirmed_bits));
            end else begin
                want = confirm_q.pop_front();
                results_seen++;
                if (o_confirmed_bits !== want)
                    report_mismatch($sformatf("confirmed_bits %h, expected %h",
                                              o_confirmed_bits, want));
            end
        end
    end

    initial begin : run_tests
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_thresholds();
        test_polarity_and_widths();
        test_lowered_threshold();
        test_timestamp_wrap();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (confirm_q.size() != 0)
            report_mismatch($sformatf("%0d results never came out", confirm_q.size()));
        $display("Ran %0d samples through %0d register writes, %0d results compared.",
                 samples_sent, reg_writes, results_seen);
        $display("Directed edges, zero and max thresholds, timestamp wrap; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/macd_pkg.sv
hw/rtl/macd_chan.sv
hw/rtl/multi_channel_asymmetric_debouncer.sv
tb/sv/tb_multi_channel_asymmetric_debouncer.sv
